/* rtl/assert_macros.svh */
// Assertion macros used by the interpolator unit to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An antecedent that holds in a cycle implies a consequent in the same cycle.
`define SWI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in segment waypoint interpolator");

// An antecedent that holds in a cycle implies a consequent in the next cycle.
`define SWI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in segment waypoint interpolator");

`endif

/* rtl/swi_pkg.sv */
package swi_pkg;

    localparam int MaxSteps  = 63;
    localparam int StepW     = 6;
    localparam int CoordW    = 32;
    localparam int DiffW     = 33;
    localparam int SpcW      = 32;
    localparam int MinW      = 16;
    localparam int HalfW     = 17;
    localparam int PpW       = 34;
    localparam int LenSqW    = 66;
    localparam int SpcSqW    = 64;
    localparam int MinSqW    = 32;
    localparam int ReachSqW  = 77;
    localparam int DeltaW    = 71;
    localparam int RemW      = 7;
    localparam int CordW     = 36;
    localparam int AngW      = 27;
    localparam int IterW     = 5;
    localparam int CordIters = 24;
    localparam int HeadW     = 16;
    localparam int CntW      = 6;
    localparam int SqSlots   = 16;
    localparam int DivCycles = 33;
    localparam int CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] CfgSpacing = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMinLen  = 2'd1;

    localparam logic [1:0] PartLoLo = 2'd0;
    localparam logic [1:0] PartHiLo = 2'd1;
    localparam logic [1:0] PartHiHi = 2'd2;

    localparam logic [1:0] SqDx  = 2'd0;
    localparam logic [1:0] SqDy  = 2'd1;
    localparam logic [1:0] SqSpc = 2'd2;
    localparam logic [1:0] SqMin = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_CHECK,
        S_SEARCH,
        S_DIVIDE,
        S_PREP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       sq_issue;
        logic [3:0] sq_idx;
        logic       init_search;
        logic       search_step;
        logic       search_done;
        logic       div_step;
        logic       emit_init;
        logic       emit_load;
        logic       emit_adv;
    } t_ctrl_cmd;

    typedef struct packed {
        logic len_short;
        logic search_hit;
        logic cordic_done;
        logic out_free;
        logic at_first;
        logic at_last;
        logic omit;
    } t_ctrl_sts;

    function automatic logic [AngW-1:0] cordic_angle(input logic [IterW-1:0] idx);
        logic [AngW-1:0] a;
        case (idx)
            5'd0:    a = 27'd4194304;
            5'd1:    a = 27'd2476042;
            5'd2:    a = 27'd1308273;
            5'd3:    a = 27'd664100;
            5'd4:    a = 27'd333339;
            5'd5:    a = 27'd166832;
            5'd6:    a = 27'd83436;
            5'd7:    a = 27'd41721;
            5'd8:    a = 27'd20861;
            5'd9:    a = 27'd10430;
            5'd10:   a = 27'd5215;
            5'd11:   a = 27'd2608;
            5'd12:   a = 27'd1304;
            5'd13:   a = 27'd652;
            5'd14:   a = 27'd326;
            5'd15:   a = 27'd163;
            5'd16:   a = 27'd81;
            5'd17:   a = 27'd41;
            5'd18:   a = 27'd20;
            5'd19:   a = 27'd10;
            5'd20:   a = 27'd5;
            5'd21:   a = 27'd3;
            5'd22:   a = 27'd1;
            5'd23:   a = 27'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/swi_seg_if.sv */
interface swi_seg_if;
    import swi_pkg::*;

    logic              valid;
    logic              ready;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic              omit_start;

    modport source (output valid, start_x, start_y, end_x, end_y, omit_start, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, omit_start, output ready);
endinterface

/* rtl/swi_pt_if.sv */
interface swi_pt_if;
    import swi_pkg::*;

    logic              valid;
    logic              ready;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [HeadW-1:0]  heading;
    logic              final_point;

    modport source (output valid, point_x, point_y, heading, final_point, input ready);
    modport sink (input valid, point_x, point_y, heading, final_point, output ready);
endinterface

/* rtl/swi_ctrl.sv */
module swi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_seg_valid,
    output logic                o_seg_ready,
    input  swi_pkg::t_ctrl_sts  i_sts,
    output swi_pkg::t_ctrl_cmd  o_cmd
);
    import swi_pkg::*;

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_seg_ready = 1'b0;
        o_cmd.sq_idx = r_cnt[3:0];
        case (r_state)
            S_IDLE: begin
                o_seg_ready = 1'b1;
                if (i_seg_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.sq_issue = (r_cnt < CntW'(SqSlots));
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CntW'(SqSlots)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.len_short) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.init_search = 1'b1;
                    n_state           = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.search_hit) begin
                    o_cmd.search_done = 1'b1;
                    n_cnt             = '0;
                    n_state           = S_DIVIDE;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CntW'(DivCycles - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.cordic_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.at_first && i_sts.omit) begin
                    o_cmd.emit_adv = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

/* rtl/swi_datapath.sv */
module swi_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swi_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [swi_pkg::SpcW-1:0]     i_cfg_data,
    input  logic [swi_pkg::CoordW-1:0]   i_start_x,
    input  logic [swi_pkg::CoordW-1:0]   i_start_y,
    input  logic [swi_pkg::CoordW-1:0]   i_end_x,
    input  logic [swi_pkg::CoordW-1:0]   i_end_y,
    input  logic                         i_omit_start,
    input  swi_pkg::t_ctrl_cmd           i_cmd,
    output swi_pkg::t_ctrl_sts           o_sts,
    input  logic                         i_pt_ready,
    output logic                         o_pt_valid,
    output logic [swi_pkg::CoordW-1:0]   o_point_x,
    output logic [swi_pkg::CoordW-1:0]   o_point_y,
    output logic [swi_pkg::HeadW-1:0]    o_heading,
    output logic                         o_final_point
);
    import swi_pkg::*;

    logic [SpcW-1:0]       r_spacing;
    logic [MinW-1:0]       r_min_len;

    logic [CoordW-1:0]     r_x0, r_y0;
    logic [DiffW-1:0]      r_magx, r_magy;
    logic                  r_negx, r_negy, r_omit;

    logic [PpW-1:0]        n_pp_raw;
    logic [LenSqW-1:0]     r_pp;
    logic [1:0]            r_pp_tgt;
    logic                  r_pp_v;
    logic [LenSqW-1:0]     r_len2;
    logic [SpcSqW-1:0]     r_s2;
    logic [MinSqW-1:0]     r_m2;

    logic [ReachSqW-1:0]   r_sq;
    logic [DeltaW-1:0]     r_dq;
    logic [StepW-1:0]      r_n, r_steps;

    logic [DiffW-1:0]      r_dvx, r_dvy;
    logic [StepW-1:0]      r_rmx, r_rmy;

    logic [DiffW-1:0]      r_quox, r_quoy, r_qx, r_qy;
    logic [RemW-1:0]       r_rrx, r_rry, r_rex, r_rey;
    logic [StepW-1:0]      r_i;

    logic signed [CordW-1:0] r_cx, r_cy;
    logic signed [AngW-1:0]  r_cz;
    logic [IterW-1:0]        r_citer;
    logic                    r_crun, r_czero;

    logic                  r_out_v;

    logic [DiffW-1:0]      dx, dy, sq_op;
    logic [HalfW-1:0]      sq_hi, sq_lo, mul_a, mul_b;
    logic [LenSqW-1:0]     pp_aligned;
    logic [RemW-1:0]       trial_x, trial_y, two_s;
    logic [RemW:0]         sum_x, sum_y;
    logic                  ge_x, ge_y, wrap_x, wrap_y;
    logic signed [CordW-1:0] sx, sy;
    logic signed [AngW-1:0]  zr;
    logic [CoordW-1:0]     offx, offy;

    assign dx = {i_end_x[CoordW-1], i_end_x} - {i_start_x[CoordW-1], i_start_x};
    assign dy = {i_end_y[CoordW-1], i_end_y} - {i_start_y[CoordW-1], i_start_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SpcW'(65536);
            r_min_len <= MinW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgSpacing: r_spacing <= i_cfg_data;
                CfgMinLen:  r_min_len <= i_cfg_data[MinW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.sq_idx[3:2])
            SqDx:    sq_op = r_magx;
            SqDy:    sq_op = r_magy;
            SqSpc:   sq_op = {1'b0, r_spacing};
            default: sq_op = {(DiffW - MinW)'(0), r_min_len};
        endcase
        sq_hi = sq_op[DiffW-1:16];
        sq_lo = {1'b0, sq_op[15:0]};
        case (i_cmd.sq_idx[1:0])
            PartLoLo: begin mul_a = sq_lo; mul_b = sq_lo; end
            PartHiLo: begin mul_a = sq_hi; mul_b = sq_lo; end
            PartHiHi: begin mul_a = sq_hi; mul_b = sq_hi; end
            default:  begin mul_a = '0;    mul_b = '0;    end
        endcase
        n_pp_raw = PpW'(mul_a * mul_b);
        case (i_cmd.sq_idx[1:0])
            PartHiLo: pp_aligned = LenSqW'(n_pp_raw) << 17;
            PartHiHi: pp_aligned = LenSqW'(n_pp_raw) << 32;
            default:  pp_aligned = LenSqW'(n_pp_raw);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_v <= 1'b0;
        end else begin
            r_pp_v <= i_cmd.sq_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0   <= i_start_x;
            r_y0   <= i_start_y;
            r_negx <= dx[DiffW-1];
            r_negy <= dy[DiffW-1];
            r_magx <= dx[DiffW-1] ? (~dx + 1'b1) : dx;
            r_magy <= dy[DiffW-1] ? (~dy + 1'b1) : dy;
            r_omit <= i_omit_start;
            r_len2 <= '0;
            r_s2   <= '0;
            r_m2   <= '0;
        end else if (r_pp_v) begin
            case (r_pp_tgt)
                SqSpc:   r_s2   <= r_s2 + r_pp[SpcSqW-1:0];
                SqMin:   r_m2   <= r_m2 + r_pp[MinSqW-1:0];
                default: r_len2 <= r_len2 + r_pp;
            endcase
        end
        if (i_cmd.sq_issue) begin
            r_pp     <= pp_aligned;
            r_pp_tgt <= i_cmd.sq_idx[3:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_search) begin
            r_n  <= StepW'(1);
            r_sq <= ReachSqW'(r_s2);
            r_dq <= DeltaW'(r_s2) + (DeltaW'(r_s2) << 1);
        end else if (i_cmd.search_step) begin
            r_n  <= r_n + 1'b1;
            r_sq <= r_sq + ReachSqW'(r_dq);
            r_dq <= r_dq + (DeltaW'(r_s2) << 1);
        end
    end

    assign trial_x = {r_rmx, r_dvx[DiffW-1]};
    assign trial_y = {r_rmy, r_dvy[DiffW-1]};
    assign ge_x    = trial_x >= {1'b0, r_steps};
    assign ge_y    = trial_y >= {1'b0, r_steps};

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_done) begin
            r_steps <= r_n;
            r_dvx   <= r_magx;
            r_dvy   <= r_magy;
            r_rmx   <= '0;
            r_rmy   <= '0;
        end else if (i_cmd.div_step) begin
            r_dvx <= {r_dvx[DiffW-2:0], ge_x};
            r_dvy <= {r_dvy[DiffW-2:0], ge_y};
            r_rmx <= ge_x ? StepW'(trial_x - {1'b0, r_steps}) : trial_x[StepW-1:0];
            r_rmy <= ge_y ? StepW'(trial_y - {1'b0, r_steps}) : trial_y[StepW-1:0];
        end
    end

    assign two_s  = {r_steps, 1'b0};
    assign sum_x  = {1'b0, r_rex} + {1'b0, r_rrx};
    assign sum_y  = {1'b0, r_rey} + {1'b0, r_rry};
    assign wrap_x = sum_x >= {1'b0, two_s};
    assign wrap_y = sum_y >= {1'b0, two_s};

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_init) begin
            r_quox <= r_dvx;
            r_quoy <= r_dvy;
            r_rrx  <= {r_rmx, 1'b0};
            r_rry  <= {r_rmy, 1'b0};
            r_qx   <= '0;
            r_qy   <= '0;
            r_rex  <= {1'b0, r_steps};
            r_rey  <= {1'b0, r_steps};
            r_i    <= '0;
        end else if (i_cmd.emit_adv) begin
            r_i   <= r_i + 1'b1;
            r_qx  <= r_qx + r_quox + DiffW'(wrap_x);
            r_qy  <= r_qy + r_quoy + DiffW'(wrap_y);
            r_rex <= wrap_x ? RemW'(sum_x - {1'b0, two_s}) : sum_x[RemW-1:0];
            r_rey <= wrap_y ? RemW'(sum_y - {1'b0, two_s}) : sum_y[RemW-1:0];
        end
    end

    assign sx = r_cx >>> r_citer;
    assign sy = r_cy >>> r_citer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crun <= 1'b0;
        end else if (i_cmd.capture) begin
            r_crun <= 1'b1;
        end else if (r_crun && r_citer == IterW'(CordIters - 1)) begin
            r_crun <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_citer <= '0;
            r_czero <= (dx == '0) && (dy == '0);
            if (dx[DiffW-1]) begin
                r_cx <= -CordW'($signed(dx));
                r_cy <= -CordW'($signed(dy));
                r_cz <= dy[DiffW-1] ? -AngW'(32'sd16777216) : AngW'(32'sd16777216);
            end else begin
                r_cx <= CordW'($signed(dx));
                r_cy <= CordW'($signed(dy));
                r_cz <= '0;
            end
        end else if (r_crun) begin
            r_citer <= r_citer + 1'b1;
            if (r_cy > 0) begin
                r_cx <= r_cx + sy;
                r_cy <= r_cy - sx;
                r_cz <= r_cz + $signed(cordic_angle(r_citer));
            end else begin
                r_cx <= r_cx - sy;
                r_cy <= r_cy + sx;
                r_cz <= r_cz - $signed(cordic_angle(r_citer));
            end
        end
    end

    assign zr   = r_cz + AngW'(256);
    assign offx = r_negx ? (~r_qx[CoordW-1:0] + 1'b1) : r_qx[CoordW-1:0];
    assign offy = r_negy ? (~r_qy[CoordW-1:0] + 1'b1) : r_qy[CoordW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_v <= 1'b1;
        end else if (i_pt_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_point_x     <= r_x0 + offx;
            o_point_y     <= r_y0 + offy;
            o_heading     <= r_czero ? '0 : zr[24:9];
            o_final_point <= (r_i == r_steps);
        end
    end

    assign o_pt_valid        = r_out_v;
    assign o_sts.len_short   = r_len2 < LenSqW'(r_m2);
    assign o_sts.search_hit  = (r_sq >= ReachSqW'(r_len2)) || (r_n == StepW'(MaxSteps));
    assign o_sts.cordic_done = !r_crun;
    assign o_sts.out_free    = !r_out_v || i_pt_ready;
    assign o_sts.at_first    = (r_i == '0);
    assign o_sts.at_last     = (r_i == r_steps);
    assign o_sts.omit        = r_omit;
endmodule

/* rtl/segment_waypoint_interpolator_unit.sv */
// Segment waypoint interpolator.
// The input channel i_seg carries one segment per transfer: start and end points in
// signed Q16.16 and an omit_start flag. The output channel o_pt carries one waypoint
// per transfer with its heading; final_point marks the end point of the segment.
// The spacing and minimum length registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. A segment is taken only while the block is idle,
// and the block stays busy until its last waypoint sits in the output register.
// The squares are formed on one shared 17x17 multiplier, the step search tries the
// step counts in turn, and the two restoring dividers run before the first waypoint
// is ready. The heading CORDIC runs alongside the squares. Waypoints then leave at
// one per cycle while the receiver is ready; a segment shorter than the minimum
// gives no waypoints. When the receiver stalls, the output register holds its
// waypoint and the next one waits. Reset returns the spacing and minimum length
// registers to their reset values, empties the output register and drops any
// segment at work.
`include "assert_macros.svh"

module segment_waypoint_interpolator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swi_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [swi_pkg::SpcW-1:0]     i_cfg_data,
    swi_seg_if.sink                      i_seg,
    swi_pt_if.source                     o_pt
);
    import swi_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    swi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg.valid),
        .o_seg_ready (i_seg.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    swi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_seg.start_x),
        .i_start_y     (i_seg.start_y),
        .i_end_x       (i_seg.end_x),
        .i_end_y       (i_seg.end_y),
        .i_omit_start  (i_seg.omit_start),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pt_ready    (o_pt.ready),
        .o_pt_valid    (o_pt.valid),
        .o_point_x     (o_pt.point_x),
        .o_point_y     (o_pt.point_y),
        .o_heading     (o_pt.heading),
        .o_final_point (o_pt.final_point)
    );

    `SWI_ASSERT_NEXT(a_busy_after_seg, i_clk, i_rst_n, i_seg.valid && i_seg.ready, !i_seg.ready)
    `SWI_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, cmd.emit_load, sts.out_free)
    `SWI_ASSERT_SAME(a_emit_after_cordic, i_clk, i_rst_n, cmd.emit_init, sts.cordic_done)
endmodule

/* test/tb_segment_waypoint_interpolator_unit.sv */
module tb_segment_waypoint_interpolator_unit;
    import swi_pkg::*;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic        fin;
    } t_waypoint;

    localparam int LimitCycles = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [SpcW-1:0] i_cfg_data = '0;

    swi_seg_if seg_bus ();
    swi_pt_if pt_bus ();

    segment_waypoint_interpolator_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_seg(seg_bus.sink),
        .o_pt(pt_bus.source)
    );

    always #6 i_clk = ~i_clk;

    t_waypoint waypoints_due[$];
    int fails = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic [31:0] spacing_reg = 32'd65536;
    logic [15:0] min_len_reg = 16'd1;

    initial begin
        seg_bus.valid = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.end_x = '0;
        seg_bus.end_y = '0;
        seg_bus.omit_start = 1'b0;
        pt_bus.ready = 1'b0;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [15:0] segment_heading(longint dx, longint dy);
        longint x, y, z, nx;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0 && dy == 0) return 16'd0;
        if (dx < 0) begin
            x = -dx;
            y = -dy;
            z = (dy >= 0) ? (longint'(1) <<< 24) : -(longint'(1) <<< 24);
        end
        for (int i = 0; i < CordIters; i++) begin
            if (y > 0) begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(cordic_angle(5'(i)));
            end else begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(cordic_angle(5'(i)));
            end
            x = nx;
        end
        return 16'(floor_shift(z + 256, 9));
    endfunction

    function automatic longint scaled_offset(longint d, int i, int steps);
        logic [127:0] q;
        logic [127:0] m;
        m = (d < 0) ? 128'(-d) : 128'(d);
        q = (2 * 128'(i) * m + 128'(steps)) / (2 * 128'(steps));
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_waypoints(logic [31:0] sx, logic [31:0] sy,
                                     logic [31:0] ex, logic [31:0] ey, logic om);
        longint x0, y0, dx, dy;
        logic [127:0] len2, reach;
        int steps;
        logic [15:0] hd;
        t_waypoint w;
        x0 = longint'($signed(sx));
        y0 = longint'($signed(sy));
        dx = longint'($signed(ex)) - x0;
        dy = longint'($signed(ey)) - y0;
        len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        if (len2 < 128'(min_len_reg) * 128'(min_len_reg)) return;
        steps = MaxSteps;
        for (int n = 1; n <= MaxSteps; n++) begin
            reach = 128'(n) * 128'(spacing_reg);
            if (reach * reach >= len2) begin
                steps = n;
                break;
            end
        end
        hd = segment_heading(dx, dy);
        for (int i = int'(om); i <= steps; i++) begin
            w.px = 32'(x0 + scaled_offset(dx, i, steps));
            w.py = 32'(y0 + scaled_offset(dy, i, steps));
            w.hd = hd;
            w.fin = (i == steps);
            waypoints_due = {waypoints_due, w};
        end
    endtask

    task automatic send_segment(logic [31:0] sx, logic [31:0] sy,
                                logic [31:0] ex, logic [31:0] ey, logic om);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        seg_bus.start_x <= sx;
        seg_bus.start_y <= sy;
        seg_bus.end_x <= ex;
        seg_bus.end_y <= ey;
        seg_bus.omit_start <= om;
        seg_bus.valid <= 1'b1;
        @(posedge i_clk);
        while (!seg_bus.ready) @(posedge i_clk);
        predict_waypoints(sx, sy, ex, ey, om);
        @(negedge i_clk);
        seg_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        while (waypoints_due.size() > 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        drain_and_settle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgSpacing) spacing_reg = val;
        else if (idx == CfgMinLen) min_len_reg = val[15:0];
    endtask

    always @(posedge i_clk) begin
        t_waypoint w;
        cycles <= cycles + 1;
        if (i_rst_n && pt_bus.valid && pt_bus.ready) begin
            if (waypoints_due.size() == 0) begin
                $error("unexpected waypoint x=%h", pt_bus.point_x);
                fails++;
            end else begin
                w = waypoints_due.pop_front();
                if (pt_bus.point_x !== w.px) begin
                    $error("point_x expected %h actual %h", w.px, pt_bus.point_x);
                    fails++;
                end
                if (pt_bus.point_y !== w.py) begin
                    $error("point_y expected %h actual %h", w.py, pt_bus.point_y);
                    fails++;
                end
                if (pt_bus.heading !== w.hd) begin
                    $error("heading expected %h actual %h", w.hd, pt_bus.heading);
                    fails++;
                end
                if (pt_bus.final_point !== w.fin) begin
                    $error("final_point expected %b actual %b", w.fin, pt_bus.final_point);
                    fails++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        pt_bus.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (cycles > LimitCycles) begin
            $display("** segment_waypoint_interpolator_unit: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        send_segment(32'h0, 32'h0, 32'h0003_0000, 32'h0, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0002_8000, 1'b1);
        send_segment(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 1'b0);
        send_segment(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
        send_segment(32'h0, 32'h0, 32'hFFFD_0000, 32'hFFFD_0000, 1'b1);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_segment(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        write_reg(CfgMinLen, 32'd0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_segment(32'h5, 32'h7, 32'h5, 32'h7, 1'b1);
        write_reg(CfgMinLen, 32'hFFFF);
        send_segment(32'h0, 32'h0, 32'h0000_FFFE, 32'h0, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0000_FFFF, 32'h0, 1'b0);
        write_reg(CfgSpacing, 32'd0);
        send_segment(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        write_reg(CfgSpacing, 32'hFFFF_FFFF);
        write_reg(CfgMinLen, 32'd1);
        send_segment(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_segment(32'h0, 32'h0, 32'h1, 32'h0, 1'b1);
        write_reg(CfgSpacing, 32'd1);
        send_segment(32'h0, 32'h0, 32'h3, 32'h4, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0100_0000, 32'hFF00_0000, 1'b0);
        write_reg(CfgSpacing, 32'd65536);
    endtask

    task automatic test_random(int count);
        logic [31:0] sx, sy, ex, ey, span;
        for (int k = 0; k < count; k++) begin
            sx = $urandom;
            sy = $urandom;
            case ($urandom_range(3))
                0: begin
                    ex = $urandom;
                    ey = $urandom;
                end
                1: begin
                    ex = sx + $signed($urandom_range(32'h000A_0000)) - 32'h0005_0000;
                    ey = sy + $signed($urandom_range(32'h000A_0000)) - 32'h0005_0000;
                end
                2: begin
                    span = 32'h1 << $urandom_range(30);
                    ex = sx + ($urandom & (span - 1)) - (span >> 1);
                    ey = sy + ($urandom & (span - 1)) - (span >> 1);
                end
                default: begin
                    ex = sx + $urandom_range(3) - 1;
                    ey = sy + $urandom_range(3) - 1;
                end
            endcase
            send_segment(sx, sy, ex, ey, 1'($urandom));
            if (k == count / 2) drain_and_settle();
        end
    endtask

    task automatic test_phases();
        write_reg(CfgSpacing, 32'h0002_0000 + $urandom_range(32'hFFFF));
        write_reg(CfgMinLen, $urandom_range(16'hFFFF));
        test_random(23);
        send_idle_pct = 52;
        write_reg(CfgSpacing, 32'h0000_8000);
        write_reg(CfgMinLen, 32'd0);
        test_random(23);
        send_idle_pct = 0;
        stall_pct = 52;
        write_reg(CfgSpacing, $urandom);
        test_random(23);
        send_idle_pct = 21;
        stall_pct = 21;
        write_reg(CfgSpacing, 32'd65536);
        write_reg(CfgMinLen, 32'd1);
        test_random(23);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_phases();
        drain_and_settle();
        if (fails == 0) begin
            $display("** segment_waypoint_interpolator_unit: PASSED **");
        end else begin
            $display("** segment_waypoint_interpolator_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/swi_pkg.sv
rtl/swi_seg_if.sv
rtl/swi_pt_if.sv
rtl/swi_ctrl.sv
rtl/swi_datapath.sv
rtl/segment_waypoint_interpolator_unit.sv
test/tb_segment_waypoint_interpolator_unit.sv
